@@ hdl/sha1s_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1s_pkg: shared types and constants of the SHA-1 stream hasher
// Holds the sequencer states, the control group that the sequencer drives
// into the datapath, the initial chaining vector and the block fill marks.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] chain_t;   // element 0 is the least significant word

    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned FILL_W      = 6;
    localparam int unsigned INDEX_W     = 3;

    localparam chain_t INIT_VECTOR = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam word_t K_ROUND_0 = 32'h5a827999;
    localparam word_t K_ROUND_1 = 32'h6ed9eba1;
    localparam word_t K_ROUND_2 = 32'h8f1bbcdc;
    localparam word_t K_ROUND_3 = 32'hca62c1d6;

    localparam logic [ROUND_W-1:0] ROUND_SCHED_END = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_3   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST      = 7'd79;

    localparam logic [FILL_W-1:0]  FILL_LEN_START  = 6'd56;
    localparam logic [FILL_W-1:0]  FILL_LAST       = 6'd63;

    localparam logic [7:0]         PAD_BYTE        = 8'h80;
    localparam logic [INDEX_W-1:0] WORD_LAST       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // Control group from the sequencer to the schedule and round units
    typedef struct packed {
        logic shift_byte;   // shift one byte into the block buffer
        logic step;         // run one compression round
        logic early;        // round index below 16: use the loaded words
        logic load;         // copy chaining value into working registers
        logic finalize;     // add working registers into chaining value
        logic reinit;       // return chaining value to the initial vector
    } ctl_t;

endpackage

@@ hdl/sha1s_sched.sv @@
// ----------------------------------------------------------------------------
// sha1s_sched: block buffer and rolling message schedule
// Bytes shift in big-endian; during compression the sixteen words rotate one
// place per round and the newest schedule word enters at the tail.
// ----------------------------------------------------------------------------
module sha1s_sched
(
    input  logic                clk,
    input  sha1s_pkg::ctl_t     ctl,
    input  logic [7:0]          byte_in,
    output sha1s_pkg::word_t    wt
);

    sha1s_pkg::word_t w_reg  [sha1s_pkg::BLOCK_WORDS];
    sha1s_pkg::word_t w_next [sha1s_pkg::BLOCK_WORDS];
    sha1s_pkg::word_t w_mix;

    // W[t] from W[t-3], W[t-8], W[t-14], W[t-16]; oldest word sits at index 0
    always_comb
    begin
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wt    = ctl.early ? w_reg[0] : {w_mix[30:0], w_mix[31]};
    end

    always_comb
    begin
        for (int i = 0; i < sha1s_pkg::BLOCK_WORDS; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (ctl.shift_byte)
        begin
            for (int i = 0; i < sha1s_pkg::BLOCK_WORDS - 1; i++)
            begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[sha1s_pkg::BLOCK_WORDS-1] =
                {w_reg[sha1s_pkg::BLOCK_WORDS-1][23:0], byte_in};
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < sha1s_pkg::BLOCK_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[sha1s_pkg::BLOCK_WORDS-1] = wt;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sha1s_pkg::BLOCK_WORDS; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

endmodule

@@ hdl/sha1s_round.sv @@
// ----------------------------------------------------------------------------
// sha1s_round: shared compression round unit and chaining value
// One round per step on the working registers a..e; finalize folds them into
// the chaining value.
// ----------------------------------------------------------------------------
module sha1s_round
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sha1s_pkg::ctl_t                     ctl,
    input  logic [sha1s_pkg::ROUND_W-1:0]       round,
    input  sha1s_pkg::word_t                    wt,
    output sha1s_pkg::chain_t                   chain
);

    sha1s_pkg::chain_t h_reg, h_next;
    sha1s_pkg::word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1s_pkg::word_t  a_next, b_next, c_next, d_next, e_next;
    sha1s_pkg::word_t  f_val, k_val, sum;

    // Round function and constant per group of twenty rounds
    always_comb
    begin
        if (round < sha1s_pkg::ROUND_PHASE_1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1s_pkg::K_ROUND_0;
        end
        else if (round < sha1s_pkg::ROUND_PHASE_2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1s_pkg::K_ROUND_1;
        end
        else if (round < sha1s_pkg::ROUND_PHASE_3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1s_pkg::K_ROUND_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1s_pkg::K_ROUND_3;
        end
        sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + wt;
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (ctl.load)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end
        else if (ctl.step)
        begin
            a_next = sum;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    always_comb
    begin
        h_next = h_reg;
        if (ctl.reinit)
        begin
            h_next = sha1s_pkg::INIT_VECTOR;
        end
        else if (ctl.finalize)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha1s_pkg::INIT_VECTOR;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    assign chain = h_reg;

endmodule

@@ hdl/sha1_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha1_stream_hasher: SHA-1 digest over a byte stream
// Absorbs message bytes, compresses each full 64-byte block with one shared
// round unit, pads on finish and returns the five digest words.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload                           | Dir
//  --------+----------------------+-----------------------------------+----
//  input   | in_valid / in_ready  | op, data_byte                     | in
//  output  | out_valid / out_ready| digest_word, word_index, last_word| out
//
// A data byte is taken while idle; the byte that completes a block then runs
// 80 rounds on the round unit and a fold into the chaining value.
// A finish transaction shifts pad and length bytes one per cycle up to the end
// of the block (at most 64, or 72 with an overflow block), compresses each
// padded block, then presents five digest transactions.
// in_ready is high only while the sequencer is idle; the output channel may
// stall freely, the digest holds until every word is taken.
// After reset (rst_n low, asynchronous) the chaining value holds the initial
// vector and the byte count is zero; the same state returns after each digest.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1s_pkg::state_t  state_reg, state_next;
    sha1s_pkg::ctl_t    ctl;
    sha1s_pkg::word_t   wt;
    sha1s_pkg::chain_t  chain;

    logic [sha1s_pkg::ROUND_W-1:0]  round_reg;     // compression round index
    logic [sha1s_pkg::FILL_W-1:0]   fill_reg;      // byte position in block
    logic [sha1s_pkg::COUNT_W-1:0]  msg_reg;       // message bytes absorbed
    logic [sha1s_pkg::LEN_W-1:0]    len_reg;       // bit length, shifts out
    logic [sha1s_pkg::INDEX_W-1:0]  oidx_reg;      // digest word on output
    logic                           fin_reg;       // finish in progress
    logic                           len_ok_reg;    // length fits this block
    logic                           len_done_reg;  // length fully shifted in

    logic [7:0] byte_sel;
    logic       len_sel;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Length bytes go in the last eight slots of the block that carries them
    assign len_sel = len_ok_reg && (fill_reg >= sha1s_pkg::FILL_LEN_START);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1s_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (fill_reg == sha1s_pkg::FILL_LAST)
                    begin
                        state_next = sha1s_pkg::ST_ROUND;
                    end
                    else if (op)
                    begin
                        state_next = sha1s_pkg::ST_PAD;
                    end
                end
            end
            sha1s_pkg::ST_PAD:
            begin
                if (fill_reg == sha1s_pkg::FILL_LAST)
                begin
                    state_next = sha1s_pkg::ST_ROUND;
                end
            end
            sha1s_pkg::ST_ROUND:
            begin
                if (round_reg == sha1s_pkg::ROUND_LAST)
                begin
                    state_next = sha1s_pkg::ST_FINAL;
                end
            end
            sha1s_pkg::ST_FINAL:
            begin
                if (len_done_reg)
                begin
                    state_next = sha1s_pkg::ST_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = sha1s_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1s_pkg::ST_IDLE;
                end
            end
            sha1s_pkg::ST_OUT:
            begin
                if (out_ready && (oidx_reg == sha1s_pkg::WORD_LAST))
                begin
                    state_next = sha1s_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1s_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and datapath controls
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        byte_sel       = 8'h00;
        ctl.shift_byte = 1'b0;
        ctl.step       = 1'b0;
        ctl.early      = (round_reg < sha1s_pkg::ROUND_SCHED_END);
        ctl.load       = 1'b0;
        ctl.finalize   = 1'b0;
        ctl.reinit     = 1'b0;
        case (state_reg)
            sha1s_pkg::ST_IDLE:
            begin
                // a finish transaction places the pad byte right away
                in_ready       = 1'b1;
                ctl.shift_byte = in_valid;
                byte_sel       = op ? sha1s_pkg::PAD_BYTE : data_byte;
                ctl.load       = in_valid && (fill_reg == sha1s_pkg::FILL_LAST);
            end
            sha1s_pkg::ST_PAD:
            begin
                ctl.shift_byte = 1'b1;
                byte_sel       = len_sel ? len_reg[sha1s_pkg::LEN_W-1 -: 8] : 8'h00;
                ctl.load       = (fill_reg == sha1s_pkg::FILL_LAST);
            end
            sha1s_pkg::ST_ROUND:
            begin
                ctl.step = 1'b1;
            end
            sha1s_pkg::ST_FINAL:
            begin
                ctl.finalize = 1'b1;
            end
            sha1s_pkg::ST_OUT:
            begin
                out_valid  = 1'b1;
                ctl.reinit = out_ready && (oidx_reg == sha1s_pkg::WORD_LAST);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1s_pkg::ST_IDLE;
            round_reg    <= '0;
            fill_reg     <= '0;
            msg_reg      <= '0;
            oidx_reg     <= '0;
            fin_reg      <= 1'b0;
            len_ok_reg   <= 1'b0;
            len_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // advance the block position on every shifted byte; wraps at 64
            if (ctl.shift_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
            end

            // count only message bytes, modulo 2^61
            if (in_fire && !op)
            begin
                msg_reg <= msg_reg + 1'b1;
            end

            if (in_fire && op)
            begin
                fin_reg    <= 1'b1;
                len_ok_reg <= (fill_reg < sha1s_pkg::FILL_LEN_START);
            end

            // the length needs a fresh block after an overflow compression
            if (ctl.finalize && fin_reg)
            begin
                len_ok_reg <= 1'b1;
            end

            if ((state_reg == sha1s_pkg::ST_PAD) && len_sel &&
                (fill_reg == sha1s_pkg::FILL_LAST))
            begin
                len_done_reg <= 1'b1;
            end

            if (ctl.step)
            begin
                round_reg <= (round_reg == sha1s_pkg::ROUND_LAST) ?
                             '0 : round_reg + 1'b1;
            end

            if (out_fire)
            begin
                oidx_reg <= (oidx_reg == sha1s_pkg::WORD_LAST) ? '0 : oidx_reg + 1'b1;
            end

            // drop all message state once the last digest word is taken
            if (ctl.reinit)
            begin
                msg_reg      <= '0;
                fin_reg      <= 1'b0;
                len_ok_reg   <= 1'b0;
                len_done_reg <= 1'b0;
            end
        end
    end

    // Bit length latched on finish; shifts out one byte per length slot
    always_ff @(posedge clk)
    begin
        if (in_fire && op)
        begin
            len_reg <= {msg_reg, 3'b000};
        end
        else if ((state_reg == sha1s_pkg::ST_PAD) && len_sel)
        begin
            len_reg <= {len_reg[sha1s_pkg::LEN_W-9:0], 8'h00};
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    sha1s_sched u_sched
    (
        .clk     (clk),
        .ctl     (ctl),
        .byte_in (byte_sel),
        .wt      (wt)
    );

    sha1s_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .round (round_reg),
        .wt    (wt),
        .chain (chain)
    );

    // Digest word select
    always_comb
    begin
        case (oidx_reg)
            3'd0:    digest_word = chain[0];
            3'd1:    digest_word = chain[1];
            3'd2:    digest_word = chain[2];
            3'd3:    digest_word = chain[3];
            default: digest_word = chain[4];
        endcase
    end

    assign word_index = oidx_reg;
    assign last_word  = (oidx_reg == sha1s_pkg::WORD_LAST);

`ifndef SYNTH
    // the two channels never open at the same time
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output channels open together");

    // round index rests at zero outside compression
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha1s_pkg::ST_ROUND) |-> (round_reg == '0))
        else $error("round index not parked");

    // digest is only shown on a block boundary
    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_reg == '0) && len_done_reg)
        else $error("digest shown mid block");

    // taking the last word returns the block to idle with fresh state
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_word) |=> in_ready && (msg_reg == '0) && !fin_reg)
        else $error("state not cleared after digest");
`endif

endmodule

@@ tb/sha1_digest_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_digest_checker: digest predictor and scoreboard for the stream hasher
// Watches both channels, hashes every accepted byte on its own, queues the
// five predicted digest words per finish transaction and compares each
// digest transaction against the oldest queued word, field by field.
// ----------------------------------------------------------------------------
package sha1_tb_ops_pkg;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } hash_op_t;

endpackage

module sha1_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int unsigned fail_count,
    output int unsigned expected_left,
    output int unsigned words_checked,
    output int unsigned bytes_absorbed,
    output int unsigned messages_done,
    output int unsigned empty_messages,
    output int unsigned overflow_pads
);

    typedef struct packed {
        sha1s_pkg::word_t                 value;
        logic [sha1s_pkg::INDEX_W-1:0]    pos;
        logic                             is_last;
    } digest_entry_t;

    sha1s_pkg::word_t              chain_regs [sha1s_pkg::CHAIN_WORDS];
    sha1s_pkg::word_t              block_buf  [sha1s_pkg::BLOCK_WORDS];
    logic [sha1s_pkg::COUNT_W-1:0] byte_total;
    digest_entry_t                 digest_q [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic restart_message();
        for (int i = 0; i < sha1s_pkg::CHAIN_WORDS; i++)
        begin
            chain_regs[i] = sha1s_pkg::INIT_VECTOR[i];
        end
        for (int i = 0; i < sha1s_pkg::BLOCK_WORDS; i++)
        begin
            block_buf[i] = '0;
        end
        byte_total = '0;
    endtask

    // Big-endian: byte 0 of the block lands in bits 31:24 of word 0
    task automatic place_byte(input logic [sha1s_pkg::FILL_W-1:0] fill,
                              input logic [7:0] value);
        block_buf[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = value;
    endtask

    // 80 rounds over a rolling 16-word schedule, then fold and clear the block
    task automatic compress_block();
        sha1s_pkg::word_t w [sha1s_pkg::BLOCK_WORDS];
        sha1s_pkg::word_t a, b, c, d, e, f, k, mix, t_sum;
        a = chain_regs[0];
        b = chain_regs[1];
        c = chain_regs[2];
        d = chain_regs[3];
        e = chain_regs[4];
        for (int i = 0; i < sha1s_pkg::BLOCK_WORDS; i++)
        begin
            w[i] = block_buf[i];
        end
        for (int t = 0; t <= sha1s_pkg::ROUND_LAST; t++)
        begin
            if (t >= sha1s_pkg::ROUND_SCHED_END)
            begin
                mix = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                w[t & 15] = {mix[30:0], mix[31]};
            end
            if (t < sha1s_pkg::ROUND_PHASE_1)
            begin
                f = (b & c) | (~b & d);
                k = sha1s_pkg::K_ROUND_0;
            end
            else if (t < sha1s_pkg::ROUND_PHASE_2)
            begin
                f = b ^ c ^ d;
                k = sha1s_pkg::K_ROUND_1;
            end
            else if (t < sha1s_pkg::ROUND_PHASE_3)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1s_pkg::K_ROUND_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1s_pkg::K_ROUND_3;
            end
            t_sum = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t_sum;
        end
        chain_regs[0] += a;
        chain_regs[1] += b;
        chain_regs[2] += c;
        chain_regs[3] += d;
        chain_regs[4] += e;
        for (int i = 0; i < sha1s_pkg::BLOCK_WORDS; i++)
        begin
            block_buf[i] = '0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        logic [sha1s_pkg::FILL_W-1:0] fill;
        fill = byte_total[sha1s_pkg::FILL_W-1:0];
        place_byte(fill, value);
        byte_total++;
        bytes_absorbed++;
        if (fill == sha1s_pkg::FILL_LAST)
        begin
            compress_block();
        end
    endtask

    // Pad, append the bit length, queue the five digest words, start over
    task automatic finish_message();
        logic [sha1s_pkg::FILL_W-1:0] fill;
        logic [sha1s_pkg::LEN_W-1:0]  bit_len;
        digest_entry_t                entry;
        fill = byte_total[sha1s_pkg::FILL_W-1:0];
        if (byte_total == '0)
        begin
            empty_messages++;
        end
        place_byte(fill, sha1s_pkg::PAD_BYTE);
        if (fill >= sha1s_pkg::FILL_LEN_START)
        begin
            compress_block();
            overflow_pads++;
        end
        bit_len = {byte_total, 3'b000};
        block_buf[14] = bit_len[63:32];
        block_buf[15] = bit_len[31:0];
        compress_block();
        for (int i = 0; i < sha1s_pkg::CHAIN_WORDS; i++)
        begin
            entry.value   = chain_regs[i];
            entry.pos     = i[sha1s_pkg::INDEX_W-1:0];
            entry.is_last = (entry.pos == sha1s_pkg::WORD_LAST);
            digest_q.push_back(entry);
        end
        messages_done++;
        restart_message();
    endtask

    always @(posedge clk)
    begin
        digest_entry_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (op == sha1_tb_ops_pkg::OP_FINISH)
                    finish_message();
                else
                    absorb_byte(data_byte);
            end
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch($sformatf("digest word %h (index %0d) with none expected",
                                              digest_word, word_index));
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.value)
                        report_mismatch($sformatf("message %0d word %0d: digest_word %h, want %h",
                                                  words_checked / 5, want.pos, digest_word,
                                                  want.value));
                    if (word_index !== want.pos)
                        report_mismatch($sformatf("message %0d: word_index %0d, want %0d",
                                                  words_checked / 5, word_index, want.pos));
                    if (last_word !== want.is_last)
                        report_mismatch($sformatf("message %0d word %0d: last_word %b, want %b",
                                                  words_checked / 5, want.pos, last_word,
                                                  want.is_last));
                    words_checked++;
                end
            end
        end
        expected_left = digest_q.size();
    end

endmodule

@@ tb/tb_sha1_stream_hasher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher: stimulus and verdict for the SHA-1 stream hasher
// Feeds byte messages and finish transactions through the input channel
// under three backpressure mixes; the digest checker beside the block
// predicts every digest and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher;

    localparam int          CLK_HIGH_NS  = 6;
    localparam int          CLK_LOW_NS   = 6;
    localparam int unsigned RESET_CYCLES = 8;
    // Random stimulus sends exactly this many byte/finish transactions
    localparam int unsigned RANDOM_ITEMS = 380;
    // Pressure phases: switch mix after this many random transactions
    localparam int unsigned PHASE_SPAN   = 127;
    // Worst finish: 72 pad bytes, two compressions, five words;
    // wait this long after the last digest word for any stray transaction
    localparam int unsigned DRAIN_CYCLES = 400;
    // Watchdog limit, set well above what a run of nothing but overflow finishes
    // under the heaviest stalls needs
    localparam int unsigned CYCLE_LIMIT  = 500_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        op        = sha1_tb_ops_pkg::OP_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int unsigned send_gap_pct   = 18;
    int unsigned recv_stall_pct = 83;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;

    int unsigned fail_count;
    int unsigned expected_left;
    int unsigned words_checked;
    int unsigned bytes_absorbed;
    int unsigned messages_done;
    int unsigned empty_messages;
    int unsigned overflow_pads;

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    always
    begin
        #(CLK_LOW_NS)  clk = 1'b1;
        #(CLK_HIGH_NS) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Bail out if the block hangs: a missing digest word or a stuck in_ready
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d digest words outstanding",
                 cycle_count, expected_left);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Block under test and the digest checker beside it
    // ------------------------------------------------------------------------
    sha1_stream_hasher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha1_digest_checker digest_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .fail_count     (fail_count),
        .expected_left  (expected_left),
        .words_checked  (words_checked),
        .bytes_absorbed (bytes_absorbed),
        .messages_done  (messages_done),
        .empty_messages (empty_messages),
        .overflow_pads  (overflow_pads)
    );

    // ------------------------------------------------------------------------
    // Output side: stall the digest channel at the current phase's rate.
    // A rate of zero keeps out_ready high for a stretch with no stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Input side: present one transaction and hold it until accepted.
    // Idle cycles go in front of the transaction, so a gap can open right
    // after any acceptance, including the byte that starts a compression or
    // the finish that starts the padding pass.
    // ------------------------------------------------------------------------
    task automatic send_item(input sha1_tb_ops_pkg::hash_op_t kind, input logic [7:0] value);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        data_byte <= value;
        // hold valid and payload until the edge where in_ready is seen high
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Message lengths: often short, many around the pad boundary (55/56)
    // and the full-block mark (64), a few spanning two blocks
    function automatic int unsigned pick_length();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(12);
            4, 5, 6:    return $urandom_range(66, 52);
            7:          return $urandom_range(130, 118);
            default:    return $urandom_range(140);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_start;
        int unsigned msg_len;
        int unsigned done_random;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message; the byte on a finish transaction must be ignored
        send_item(sha1_tb_ops_pkg::OP_FINISH, 8'hFF);
        // "abc", the classic short vector, with a zero byte riding on finish
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h61);
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h62);
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h63);
        send_item(sha1_tb_ops_pkg::OP_FINISH, 8'h00);
        // Extreme byte values, then a second empty message right after a
        // digest to check the return to the initial vector
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h00);
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'hFF);
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h80);
        send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'h7F);
        send_item(sha1_tb_ops_pkg::OP_FINISH, 8'hA5);
        send_item(sha1_tb_ops_pkg::OP_FINISH, 8'h5A);

        // Random messages; advance the pressure mix by transaction count:
        // slow receiver first, then slow sender, then no idling at all
        random_start = items_sent;
        done_random  = 0;
        while (done_random < RANDOM_ITEMS)
        begin
            if (done_random >= 2 * PHASE_SPAN)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            else if (done_random >= PHASE_SPAN)
            begin
                send_gap_pct   = 83;
                recv_stall_pct = 18;
            end
            // trim the message so its finish lands within the budget
            msg_len = pick_length();
            if (msg_len >= RANDOM_ITEMS - done_random)
            begin
                msg_len = RANDOM_ITEMS - done_random - 1;
            end
            repeat (msg_len) send_item(sha1_tb_ops_pkg::OP_ABSORB, 8'($urandom_range(255)));
            send_item(sha1_tb_ops_pkg::OP_FINISH, 8'($urandom_range(255)));
            done_random = items_sent - random_start;
        end

        // Drop valid, then wait for every predicted digest word to arrive
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d messages (%0d empty, %0d needing an overflow pad block), %0d bytes",
                 messages_done, empty_messages, overflow_pads, bytes_absorbed);
        $display("compared %0d digest words over three backpressure mixes, %0d mismatches",
                 words_checked, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
